// ----- rtl/robin_hood_hash_table_top_macros.svh -----
// Assertion macros shared by the hash table RTL.
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_MACROS_SVH

// Check that a condition implies a consequence on the same clock edge.
`define RH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rh_pkg.sv -----
// Package with sizes, codes and the slot entry type of the hash table.
package rh_pkg;

    localparam int SLOTS      = 1024;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int FULL_LIMIT = SLOTS * 15 / 16;
    localparam int FP_W       = 15;
    localparam int FP_LSB     = 49;
    localparam int HASH_W     = 64;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        RS_OK        = 3'd0,
        RS_PRESENT   = 3'd1,
        RS_NOT_FOUND = 3'd2,
        RS_FULL      = 3'd3,
        RS_EMPTY     = 3'd4
    } rsp_status_t;

    typedef struct packed {
        logic                  occ;
        logic [FP_W-1:0]       fp;
        logic [IDX_W-1:0]      probe_dist;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/rh_req_if.sv -----
// Request channel: operation, hash, key and value.
interface rh_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] hash;
    logic [31:0] key;
    logic [31:0] value;

    modport source (output valid, output mode, output hash, output key, output value,
                    input ready);
    modport sink (input valid, input mode, input hash, input key, input value,
                  output ready);
endinterface

// ----- rtl/rh_rsp_if.sv -----
// Response channel: status and returned value.
interface rh_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] value_out;

    modport source (output valid, output status, output value_out, input ready);
    modport sink (input valid, input status, input value_out, output ready);
endinterface

// ----- rtl/rh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/robin_hood_hash_table_top.sv -----
// Top level of the Robin Hood hash table with backward-shift delete.
//
//  channel | dir | payload                    | transaction
//  --------+-----+----------------------------+---------------------------
//  req     | in  | mode, hash, key, value     | valid && ready at posedge
//  rsp     | out | status, value_out          | valid && ready at posedge
//
//  After reset a clearing pass writes every slot empty, with req.ready low.
//  An item is then accepted, visits slots in the key search and, where it
//  goes on to an insert or shift walk, in that walk, and then hands its
//  result to the output register. Each slot visit reads the single slot RAM,
//  and the insert and shift walks may also write it; a new item is accepted
//  only once the last one has handed on its result.
//  A result waiting in the output register does not block acceptance of the
//  next item; only the hand-off of the following result waits for rsp.ready.
module robin_hood_hash_table_top (
    input logic         clk,
    input logic         rst_n,
    rh_req_if.sink      req,
    rh_rsp_if.source    rsp
);

    `include "robin_hood_hash_table_top_macros.svh"

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FIND  = 6'b000100,
        S_PLACE = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                           state_reg, state_next;
    rh_pkg::mode_t                    mode_reg, mode_next;
    logic [rh_pkg::IDX_W-1:0]         clr_reg, clr_next;
    logic [rh_pkg::IDX_W-1:0]         home_reg, home_next;
    logic [rh_pkg::IDX_W-1:0]         pos_reg, pos_next;
    logic [rh_pkg::IDX_W-1:0]         prev_reg, prev_next;
    logic [rh_pkg::IDX_W-1:0]         dist_reg, dist_next;
    logic [rh_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [rh_pkg::FP_W-1:0]          car_fp_reg, car_fp_next;
    logic [rh_pkg::KEY_BITS-1:0]      car_key_reg, car_key_next;
    logic [rh_pkg::VALUE_BITS-1:0]    car_val_reg, car_val_next;
    rh_pkg::rsp_status_t              res_status_reg, res_status_next;
    logic [rh_pkg::VAL_W-1:0]         res_value_reg, res_value_next;
    logic                             out_valid_reg, out_valid_next;
    rh_pkg::rsp_status_t              out_status_reg, out_status_next;
    logic [rh_pkg::VAL_W-1:0]         out_value_reg, out_value_next;

    logic                             we;
    logic [rh_pkg::IDX_W-1:0]         wr_addr;
    logic [rh_pkg::IDX_W-1:0]         rd_addr;
    rh_pkg::entry_t                   wr_data;
    rh_pkg::entry_t                   rd_data;
    logic [rh_pkg::ENTRY_W-1:0]       rd_bits;

    logic                             hit;
    logic                             miss;
    logic                             full;
    logic [rh_pkg::IDX_W-1:0]         pos_inc;
    logic [rh_pkg::IDX_W-1:0]         req_home;

    rh_ram #(
        .WIDTH (rh_pkg::ENTRY_W),
        .DEPTH (rh_pkg::SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_bits)
    );

    assign rd_data  = rh_pkg::entry_t'(rd_bits);
    assign pos_inc  = pos_reg + 1'b1;
    assign req_home = req.hash[rh_pkg::IDX_W-1:0];

    // Key match on fingerprint and key; a miss ends the search when the slot
    // is empty or the resident sits nearer its home than the probe does.
    assign hit  = rd_data.occ && (rd_data.fp == car_fp_reg) && (rd_data.key == car_key_reg);
    assign miss = !rd_data.occ || (!hit && (rd_data.probe_dist < dist_reg));
    assign full = ({1'b0, count_reg} + 1'b1) >= (rh_pkg::CNT_W + 1)'(rh_pkg::FULL_LIMIT);

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_out = out_value_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        clr_next        = clr_reg;
        home_next       = home_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        dist_next       = dist_reg;
        count_next      = count_reg;
        car_fp_next     = car_fp_reg;
        car_key_next    = car_key_reg;
        car_val_next    = car_val_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        we              = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = '0;
        rd_addr         = pos_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Write every slot empty, one a cycle.
                we       = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = req_home;
                if (req.valid)
                begin
                    mode_next       = rh_pkg::mode_t'(req.mode);
                    car_fp_next     = req.hash[rh_pkg::FP_LSB +: rh_pkg::FP_W];
                    car_key_next    = req.key[rh_pkg::KEY_BITS-1:0];
                    car_val_next    = req.value[rh_pkg::VALUE_BITS-1:0];
                    home_next       = req_home;
                    pos_next        = req_home;
                    dist_next       = '0;
                    res_value_next  = '0;
                    res_status_next = rh_pkg::RS_NOT_FOUND;
                    state_next      = S_FIND;
                    case (rh_pkg::mode_t'(req.mode))
                        rh_pkg::MODE_LOOKUP:
                        begin
                            state_next = S_FIND;
                        end
                        rh_pkg::MODE_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = rh_pkg::RS_FULL;
                                state_next      = S_DONE;
                            end
                        end
                        rh_pkg::MODE_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = rh_pkg::RS_EMPTY;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (miss)
                begin
                    if (mode_reg == rh_pkg::MODE_INSERT)
                    begin
                        // Restart from home to place the carried entry.
                        rd_addr    = home_reg;
                        pos_next   = home_reg;
                        dist_next  = '0;
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        res_status_next = rh_pkg::RS_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                end
                else if (hit)
                begin
                    if (mode_reg == rh_pkg::MODE_DELETE)
                    begin
                        prev_next  = pos_reg;
                        pos_next   = pos_inc;
                        rd_addr    = pos_inc;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        res_value_next  = rh_pkg::VAL_W'(rd_data.value);
                        res_status_next = (mode_reg == rh_pkg::MODE_INSERT) ?
                                          rh_pkg::RS_PRESENT : rh_pkg::RS_OK;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    pos_next  = pos_inc;
                    dist_next = dist_reg + 1'b1;
                    rd_addr   = pos_inc;
                end
            end
            S_PLACE:
            begin
                wr_data.occ        = 1'b1;
                wr_data.fp         = car_fp_reg;
                wr_data.probe_dist = dist_reg;
                wr_data.key        = car_key_reg;
                wr_data.value      = car_val_reg;
                if (!rd_data.occ)
                begin
                    we              = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_status_next = rh_pkg::RS_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (rd_data.probe_dist < dist_reg)
                    begin
                        // Swap: drop the carried entry here, carry the resident on.
                        we           = 1'b1;
                        car_fp_next  = rd_data.fp;
                        car_key_next = rd_data.key;
                        car_val_next = rd_data.value;
                        dist_next    = rd_data.probe_dist + 1'b1;
                    end
                    else
                    begin
                        dist_next = dist_reg + 1'b1;
                    end
                    pos_next = pos_inc;
                    rd_addr  = pos_inc;
                end
            end
            S_SHIFT:
            begin
                we      = 1'b1;
                wr_addr = prev_reg;
                if (!rd_data.occ || (rd_data.probe_dist == '0))
                begin
                    // End of run: leave the last moved-from slot empty.
                    wr_data         = '0;
                    count_next      = count_reg - 1'b1;
                    res_status_next = rh_pkg::RS_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    wr_data            = rd_data;
                    wr_data.probe_dist = rd_data.probe_dist - 1'b1;
                    prev_next          = pos_reg;
                    pos_next           = pos_inc;
                    rd_addr            = pos_inc;
                end
            end
            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        home_reg       <= home_next;
        pos_reg        <= pos_next;
        prev_reg       <= prev_next;
        dist_reg       <= dist_next;
        car_fp_reg     <= car_fp_next;
        car_key_reg    <= car_key_next;
        car_val_reg    <= car_val_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    `RH_ASSERT_IMP(a_count_below_limit, clk, rst_n, 1'b1,
        count_reg < rh_pkg::CNT_W'(rh_pkg::FULL_LIMIT), "entry count reached the full limit")
    `RH_ASSERT_IMP(a_no_write_idle, clk, rst_n, state_reg == S_IDLE || state_reg == S_DONE,
        !we, "slot RAM written outside a walk")
    `RH_ASSERT_NEXT(a_done_loads_output, clk, rst_n,
        state_reg == S_DONE && (!out_valid_reg || rsp.ready),
        out_valid_reg && state_reg == S_IDLE, "result not handed to output register")
    `RH_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, req.valid && req.ready,
        state_reg == S_FIND || state_reg == S_DONE, "accepted transaction did not start")

endmodule
